### rtl/vrc7_pkg.sv
// Shared types, beat layouts and register decode codes for the VRC7 mapper block.
package vrc7_pkg;

    // Default size of the program image in 8K pages
    localparam int PRG_PAGES_DEFAULT = 256;

    // Item kinds on the input channel
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Address decode mask and register addresses
    localparam logic [15:0] ADDR_MASK     = 16'hF038;
    localparam logic [15:0] A_PRG0        = 16'h8000;
    localparam logic [15:0] A_PRG1_A      = 16'h8008;
    localparam logic [15:0] A_PRG1_B      = 16'h8010;
    localparam logic [15:0] A_PRG2        = 16'h9000;
    localparam logic [15:0] A_SOUND_A     = 16'h9010;
    localparam logic [15:0] A_SOUND_B     = 16'h9030;
    localparam logic [15:0] A_CHR0        = 16'hA000;
    localparam logic [15:0] A_CHR1_A      = 16'hA008;
    localparam logic [15:0] A_CHR1_B      = 16'hA010;
    localparam logic [15:0] A_CHR2        = 16'hB000;
    localparam logic [15:0] A_CHR3_A      = 16'hB008;
    localparam logic [15:0] A_CHR3_B      = 16'hB010;
    localparam logic [15:0] A_CHR4        = 16'hC000;
    localparam logic [15:0] A_CHR5_A      = 16'hC008;
    localparam logic [15:0] A_CHR5_B      = 16'hC010;
    localparam logic [15:0] A_CHR6        = 16'hD000;
    localparam logic [15:0] A_CHR7_A      = 16'hD008;
    localparam logic [15:0] A_CHR7_B      = 16'hD010;
    localparam logic [15:0] A_MIRROR      = 16'hE000;
    localparam logic [15:0] A_RELOAD_A    = 16'hE008;
    localparam logic [15:0] A_RELOAD_B    = 16'hE010;
    localparam logic [15:0] A_IRQ_CTRL    = 16'hF000;
    localparam logic [15:0] A_IRQ_ACK_A   = 16'hF008;
    localparam logic [15:0] A_IRQ_ACK_B   = 16'hF010;

    // Counter wrap value
    localparam logic [7:0] COUNT_TOP = 8'hFF;

    // Number of character banks
    localparam int CHR_BANKS = 8;

    // Register targets of a decoded write
    localparam logic [3:0] TGT_NONE     = 4'd0;
    localparam logic [3:0] TGT_PRG0     = 4'd1;
    localparam logic [3:0] TGT_PRG1     = 4'd2;
    localparam logic [3:0] TGT_PRG2     = 4'd3;
    localparam logic [3:0] TGT_SOUND    = 4'd4;
    localparam logic [3:0] TGT_CHR      = 4'd5;
    localparam logic [3:0] TGT_MIRROR   = 4'd6;
    localparam logic [3:0] TGT_RELOAD   = 4'd7;
    localparam logic [3:0] TGT_IRQ_CTRL = 4'd8;
    localparam logic [3:0] TGT_IRQ_ACK  = 4'd9;

    // Decoder result: which register, and which character bank
    typedef struct packed {
        logic [3:0] target;
        logic [2:0] chr_idx;
    } dec_t;

    // Input beat
    typedef struct packed {
        logic        op;
        logic [15:0] cpu_address;
        logic [7:0]  write_value;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic        irq_pulse;
        logic [1:0]  mirror_mode;
        logic [7:0]  prg_bank_first;
        logic [7:0]  prg_bank_second;
        logic [7:0]  prg_bank_third;
        logic [31:0] chr_banks_low;
        logic [31:0] chr_banks_high;
        logic        sound_write;
        logic [15:0] sound_address;
        logic [7:0]  sound_value;
    } out_beat_t;

endpackage

### rtl/vrc7_decode.sv
// Register address decoder for CPU writes.
module vrc7_decode (
    input  logic [15:0]    cpu_address,
    output vrc7_pkg::dec_t dec
);
    import vrc7_pkg::*;

    logic [15:0] masked;

    assign masked = cpu_address & ADDR_MASK;

    // Map the masked address onto a register target
    always_comb begin
        dec.target  = TGT_NONE;
        dec.chr_idx = 3'd0;
        unique case (masked)
            A_PRG0:                  dec.target = TGT_PRG0;
            A_PRG1_A, A_PRG1_B:      dec.target = TGT_PRG1;
            A_PRG2:                  dec.target = TGT_PRG2;
            A_SOUND_A, A_SOUND_B:    dec.target = TGT_SOUND;
            A_CHR0: begin
                dec.target = TGT_CHR; dec.chr_idx = 3'd0;
            end
            A_CHR1_A, A_CHR1_B: begin
                dec.target = TGT_CHR; dec.chr_idx = 3'd1;
            end
            A_CHR2: begin
                dec.target = TGT_CHR; dec.chr_idx = 3'd2;
            end
            A_CHR3_A, A_CHR3_B: begin
                dec.target = TGT_CHR; dec.chr_idx = 3'd3;
            end
            A_CHR4: begin
                dec.target = TGT_CHR; dec.chr_idx = 3'd4;
            end
            A_CHR5_A, A_CHR5_B: begin
                dec.target = TGT_CHR; dec.chr_idx = 3'd5;
            end
            A_CHR6: begin
                dec.target = TGT_CHR; dec.chr_idx = 3'd6;
            end
            A_CHR7_A, A_CHR7_B: begin
                dec.target = TGT_CHR; dec.chr_idx = 3'd7;
            end
            A_MIRROR:                dec.target = TGT_MIRROR;
            A_RELOAD_A, A_RELOAD_B:  dec.target = TGT_RELOAD;
            A_IRQ_CTRL:              dec.target = TGT_IRQ_CTRL;
            A_IRQ_ACK_A, A_IRQ_ACK_B: dec.target = TGT_IRQ_ACK;
            default:                 dec.target = TGT_NONE;
        endcase
    end

endmodule

### rtl/vrc7_mapper_banks_and_irq.sv
// Top level of the VRC7 mapper: bank registers, scanline IRQ counter, result register.
//
//   channel  dir  handshake          beat
//   s_       in   s_valid / s_ready  in_beat_t  (CPU write or scanline tick)
//   m_       out  m_valid / m_ready  out_beat_t (register view after the beat)
//
// One beat per cycle while m_ is not stalled: the decode and counter update sit
// between the state registers and the result register, so a beat's result
// appears the cycle after it is taken. s_ready stays high while the result
// register is empty or being drained, so a stall on m_ holds at most one beat.
// Synchronous active-low reset restores the bank defaults and empties the result
// register.
module vrc7_mapper_banks_and_irq #(
    parameter int PRG_PAGES = vrc7_pkg::PRG_PAGES_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vrc7_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vrc7_pkg::out_beat_t m_data
);
    import vrc7_pkg::*;

    // Mapper state
    logic [7:0]  prg_reg [3];
    logic [7:0]  chr_reg [CHR_BANKS];
    logic [1:0]  mirror_reg;
    logic [1:0]  irq_en_reg;
    logic [7:0]  irq_count_reg;
    logic [7:0]  irq_reload_reg;

    logic [7:0]  prg_next [3];
    logic [7:0]  chr_next [CHR_BANKS];
    logic [1:0]  mirror_next;
    logic [1:0]  irq_en_next;
    logic [7:0]  irq_count_next;
    logic [7:0]  irq_reload_next;

    logic        m_valid_reg;
    out_beat_t   m_data_reg;
    out_beat_t   m_data_next;

    logic        beat_in;
    logic        pulse;
    logic        snd;
    dec_t        dec;

    assign s_ready = !m_valid_reg || m_ready;
    assign beat_in = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    vrc7_decode u_decode (
        .cpu_address (s_data.cpu_address),
        .dec         (dec)
    );

    // Next state for one beat
    always_comb begin
        prg_next        = prg_reg;
        chr_next        = chr_reg;
        mirror_next     = mirror_reg;
        irq_en_next     = irq_en_reg;
        irq_count_next  = irq_count_reg;
        irq_reload_next = irq_reload_reg;
        pulse           = 1'b0;
        snd             = 1'b0;
        if (s_data.op == OP_TICK) begin
            if (irq_en_reg[1]) begin
                if (irq_count_reg == COUNT_TOP) begin
                    pulse          = 1'b1;
                    irq_count_next = irq_reload_reg;
                end else begin
                    irq_count_next = irq_count_reg + 8'd1;
                end
            end
        end else begin
            unique case (dec.target)
                TGT_PRG0:   prg_next[0] = s_data.write_value;
                TGT_PRG1:   prg_next[1] = s_data.write_value;
                TGT_PRG2:   prg_next[2] = s_data.write_value;
                TGT_SOUND:  snd = 1'b1;
                TGT_CHR:    chr_next[dec.chr_idx] = s_data.write_value;
                TGT_MIRROR: mirror_next = s_data.write_value[1:0];
                TGT_RELOAD: irq_reload_next = s_data.write_value;
                TGT_IRQ_CTRL: begin
                    irq_en_next = s_data.write_value[1:0];
                    if (s_data.write_value[1]) begin
                        irq_count_next = irq_reload_reg;
                    end
                end
                TGT_IRQ_ACK: irq_en_next = {2{irq_en_reg[0]}};
                default: ;
            endcase
        end
    end

    // Result beat built from the updated state
    always_comb begin
        m_data_next.irq_pulse       = pulse;
        m_data_next.mirror_mode     = mirror_next;
        m_data_next.prg_bank_first  = prg_next[0];
        m_data_next.prg_bank_second = prg_next[1];
        m_data_next.prg_bank_third  = prg_next[2];
        m_data_next.chr_banks_low   = {chr_next[3], chr_next[2], chr_next[1], chr_next[0]};
        m_data_next.chr_banks_high  = {chr_next[7], chr_next[6], chr_next[5], chr_next[4]};
        m_data_next.sound_write     = snd;
        m_data_next.sound_address   = snd ? s_data.cpu_address : 16'd0;
        m_data_next.sound_value     = snd ? s_data.write_value : 8'd0;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_reg[0]     <= 8'd0;
            prg_reg[1]     <= 8'd1;
            prg_reg[2]     <= 8'(PRG_PAGES - 2);
            for (int i = 0; i < CHR_BANKS; i++) begin
                chr_reg[i] <= 8'(i);
            end
            mirror_reg     <= 2'd0;
            irq_en_reg     <= 2'd0;
            irq_count_reg  <= 8'd0;
            irq_reload_reg <= 8'd0;
        end else if (beat_in) begin
            prg_reg        <= prg_next;
            chr_reg        <= chr_next;
            mirror_reg     <= mirror_next;
            irq_en_reg     <= irq_en_next;
            irq_count_reg  <= irq_count_next;
            irq_reload_reg <= irq_reload_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (beat_in) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_in) begin
            m_data_reg <= m_data_next;
        end
    end

    // A write beat never raises the interrupt
    assert property (@(posedge aclk) disable iff (!aresetn)
        beat_in && (s_data.op == OP_WRITE) |=> !m_data_reg.irq_pulse)
        else $error("irq pulse on a write beat");

    // A tick beat never reaches the sound chip
    assert property (@(posedge aclk) disable iff (!aresetn)
        beat_in && (s_data.op == OP_TICK) |=> !m_data_reg.sound_write)
        else $error("sound write on a tick beat");

    // Counter at its top reloads from the latch and pulses
    assert property (@(posedge aclk) disable iff (!aresetn)
        beat_in && (s_data.op == OP_TICK) && irq_en_reg[1] && (irq_count_reg == COUNT_TOP)
        |=> m_data_reg.irq_pulse && (irq_count_reg == $past(irq_reload_reg)))
        else $error("counter wrap did not reload or pulse");

    // A result held under stall is not overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_data_reg))
        else $error("stalled result changed");

endmodule
